// ----- rtl/core/dmp_pkg.sv -----
package dmp_pkg;

	// fixed layout of one frame word
	localparam int NUM_LANES        = 8;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int SAMPLE_BITS_DEF  = 24;

	localparam int PEAK_BITS  = 27;
	localparam int GAIN_BITS  = 24;
	localparam int GAIN_FRAC  = 23;
	localparam int CNT_BITS   = 4;
	localparam int OP_BITS    = 2;

	localparam logic [PEAK_BITS-1:0] PEAK_MAX = {PEAK_BITS{1'b1}};

	// operation codes
	localparam logic [OP_BITS-1:0] OP_MEASURE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_MIX     = 2'd1;
	localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd2;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = GAIN_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEREO_OUT    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIX_GAIN      = 2'd2;

	localparam logic [CNT_BITS-1:0]  CHANNEL_COUNT_RESET = 4'd2;
	localparam logic [GAIN_BITS-1:0] MIX_GAIN_RESET      = 24'h80_0000;

	// where one lane's sample goes
	typedef struct packed {
		logic left_en;
		logic right_en;
		logic halve;
	} lane_role_t;

endpackage

// ----- rtl/core/dmp_in_if.sv -----
interface dmp_in_if #(
	parameter int SAMPLE_BITS = dmp_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_0;
	logic signed [SAMPLE_BITS-1:0] sample_1;
	logic signed [SAMPLE_BITS-1:0] sample_2;
	logic signed [SAMPLE_BITS-1:0] sample_3;
	logic signed [SAMPLE_BITS-1:0] sample_4;
	logic signed [SAMPLE_BITS-1:0] sample_5;
	logic signed [SAMPLE_BITS-1:0] sample_6;
	logic signed [SAMPLE_BITS-1:0] sample_7;
	logic [dmp_pkg::OP_BITS-1:0]   operation;

	modport source (
		output valid, sample_0, sample_1, sample_2, sample_3,
		       sample_4, sample_5, sample_6, sample_7, operation,
		input  ready
	);
	modport sink (
		input  valid, sample_0, sample_1, sample_2, sample_3,
		       sample_4, sample_5, sample_6, sample_7, operation,
		output ready
	);
endinterface

// ----- rtl/core/dmp_out_if.sv -----
interface dmp_out_if #(
	parameter int SAMPLE_BITS = dmp_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic [dmp_pkg::PEAK_BITS-1:0] peak_sum;

	modport source (
		output valid, left_out, right_out, peak_sum,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out, peak_sum,
		output ready
	);
endinterface

// ----- rtl/core/dmp_lane.sv -----
module dmp_lane #(
	parameter int SAMPLE_BITS = dmp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          measure,
	input  dmp_pkg::lane_role_t           role,
	output logic signed [SAMPLE_BITS:0]   left_s1,
	output logic signed [SAMPLE_BITS:0]   right_s1
);
	logic signed [SAMPLE_BITS:0] ext;
	logic signed [SAMPLE_BITS:0] mag;
	logic signed [SAMPLE_BITS:0] val;

	always_comb begin
		ext = {sample[SAMPLE_BITS-1], sample};
		mag = ext[SAMPLE_BITS] ? -ext : ext;
		val = measure ? mag : ext;
		// middle channel: arithmetic shift gives the floor of half
		if (role.halve) begin
			val = val >>> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_s1  <= role.left_en  ? val : '0;
			right_s1 <= role.right_en ? val : '0;
		end
	end
endmodule

// ----- rtl/core/dmp_merge.sv -----
module dmp_merge #(
	parameter int SAMPLE_BITS = dmp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS:0]   lane_left  [dmp_pkg::NUM_LANES],
	input  logic signed [SAMPLE_BITS:0]   lane_right [dmp_pkg::NUM_LANES],
	output logic signed [SAMPLE_BITS+3:0] sum_left_s2,
	output logic signed [SAMPLE_BITS+3:0] sum_right_s2
);
	localparam int SW = SAMPLE_BITS + 4;

	logic signed [SW-1:0] acc_l;
	logic signed [SW-1:0] acc_r;

	always_comb begin
		acc_l = '0;
		acc_r = '0;
		for (int i = 0; i < dmp_pkg::NUM_LANES; i++) begin
			acc_l = acc_l + SW'(lane_left[i]);
			acc_r = acc_r + SW'(lane_right[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_left_s2  <= acc_l;
			sum_right_s2 <= acc_r;
		end
	end
endmodule

// ----- rtl/core/dmp_gain.sv -----
module dmp_gain #(
	parameter int SAMPLE_BITS = dmp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            load_s3,
	input  logic                            load_s4,
	input  logic                            mix_left,
	input  logic                            mix_right,
	input  logic [dmp_pkg::GAIN_BITS-1:0]   gain,
	input  logic signed [SAMPLE_BITS+3:0]   sum_left,
	input  logic signed [SAMPLE_BITS+3:0]   sum_right,
	output logic signed [SAMPLE_BITS-1:0]   left_s4,
	output logic signed [SAMPLE_BITS-1:0]   right_s4
);
	localparam int SW = SAMPLE_BITS + 4;
	localparam int PW = SW + dmp_pkg::GAIN_BITS + 1;
	localparam int RW = PW - dmp_pkg::GAIN_FRAC;

	localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (dmp_pkg::GAIN_FRAC - 1);
	localparam logic signed [RW-1:0] OUT_HI   = RW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [RW-1:0] OUT_LO   = -OUT_HI - RW'(1);

	logic signed [dmp_pkg::GAIN_BITS:0] gain_s;
	logic signed [PW-1:0]               prod_l_s3;
	logic signed [PW-1:0]               prod_r_s3;
	logic signed [PW-1:0]               biased_l;
	logic signed [PW-1:0]               biased_r;
	logic signed [RW-1:0]               rnd_l;
	logic signed [RW-1:0]               rnd_r;

	assign gain_s = {1'b0, gain};

	always_ff @(posedge clk) begin
		if (load_s3) begin
			prod_l_s3 <= mix_left  ? PW'(sum_left)  * PW'(gain_s) : '0;
			prod_r_s3 <= mix_right ? PW'(sum_right) * PW'(gain_s) : '0;
		end
	end

	// round half up, then clip to the sample range
	always_comb begin
		biased_l = prod_l_s3 + HALF_LSB;
		biased_r = prod_r_s3 + HALF_LSB;
		rnd_l    = RW'(biased_l >>> dmp_pkg::GAIN_FRAC);
		rnd_r    = RW'(biased_r >>> dmp_pkg::GAIN_FRAC);
	end

	function automatic logic signed [SAMPLE_BITS-1:0] clip(input logic signed [RW-1:0] x);
		logic signed [SAMPLE_BITS-1:0] y;
		if (x > OUT_HI) begin
			y = SAMPLE_BITS'(OUT_HI);
		end else if (x < OUT_LO) begin
			y = SAMPLE_BITS'(OUT_LO);
		end else begin
			y = SAMPLE_BITS'(x);
		end
		return y;
	endfunction

	always_ff @(posedge clk) begin
		if (load_s4) begin
			left_s4  <= clip(rnd_l);
			right_s4 <= clip(rnd_r);
		end
	end
endmodule

// ----- rtl/core/multichannel_downmix_peak_top.sv -----
// path: an accepted frame passes the lane, sum, product and output registers
// throughput: one frame per cycle unless result.ready stalls, set by the four-stage pipeline
//   (lanes, adder tree, gain multiply with peak update, rounding and output register)
// each stage refills as soon as the one after it moves, so bubbles close up
// reset: arst_n low clears all stage valids and both peaks at once and loads
//   channel_count 2, mono, unity gain; data registers are not reset
module multichannel_downmix_peak_top #(
	parameter int MAX_CHANNELS = dmp_pkg::MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = dmp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dmp_in_if.sink                            frame,
	dmp_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [dmp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [dmp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	localparam int NL = dmp_pkg::NUM_LANES;
	localparam int SW = SAMPLE_BITS + 4;
	// wide enough for both the sum and the peak limit
	localparam int CW = (SW + 1 > dmp_pkg::PEAK_BITS + 1) ? SW + 1 : dmp_pkg::PEAK_BITS + 1;

	// configuration registers
	logic [dmp_pkg::CNT_BITS-1:0]  channel_count_q;
	logic                          stereo_out_q;
	logic [dmp_pkg::GAIN_BITS-1:0] mix_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= dmp_pkg::CHANNEL_COUNT_RESET;
			stereo_out_q    <= 1'b0;
			mix_gain_q      <= dmp_pkg::MIX_GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmp_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[dmp_pkg::CNT_BITS-1:0];
				dmp_pkg::REG_STEREO_OUT:    stereo_out_q    <= cfg_data[0];
				dmp_pkg::REG_MIX_GAIN:      mix_gain_q      <= cfg_data[dmp_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow: a stage loads when it is empty or its word moves on
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4 = !v_s4 || result.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign frame.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= frame.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// operation travels alongside the data
	logic [dmp_pkg::OP_BITS-1:0] op_s1, op_s2;

	always_ff @(posedge clk) begin
		if (adv1) op_s1 <= frame.operation;
		if (adv2) op_s2 <= op_s1;
	end

	// lane routing from channel count and mode
	logic [dmp_pkg::CNT_BITS-1:0] n_eff;
	logic [dmp_pkg::CNT_BITS-1:0] half_n;
	logic [dmp_pkg::CNT_BITS-1:0] right_start;

	assign n_eff = (channel_count_q > dmp_pkg::CNT_BITS'(MAX_CHANNELS))
	             ? dmp_pkg::CNT_BITS'(MAX_CHANNELS) : channel_count_q;
	assign half_n      = n_eff >> 1;
	assign right_start = n_eff - half_n;

	logic signed [SAMPLE_BITS-1:0] samples [NL];

	assign samples[0] = frame.sample_0;
	assign samples[1] = frame.sample_1;
	assign samples[2] = frame.sample_2;
	assign samples[3] = frame.sample_3;
	assign samples[4] = frame.sample_4;
	assign samples[5] = frame.sample_5;
	assign samples[6] = frame.sample_6;
	assign samples[7] = frame.sample_7;

	logic                        measure;
	logic signed [SAMPLE_BITS:0] lane_l_s1 [NL];
	logic signed [SAMPLE_BITS:0] lane_r_s1 [NL];

	assign measure = (frame.operation == dmp_pkg::OP_MEASURE);

	for (genvar i = 0; i < NL; i++) begin : g_lane
		localparam logic [dmp_pkg::CNT_BITS-1:0] IDX = dmp_pkg::CNT_BITS'(i);

		dmp_pkg::lane_role_t role;
		logic                mid;

		// odd count in stereo: the middle channel feeds both sides at half weight
		always_comb begin
			mid = n_eff[0] && (IDX == half_n);
			if (stereo_out_q) begin
				role.left_en  = (IDX < half_n) || mid;
				role.right_en = ((IDX >= right_start) && (IDX < n_eff)) || mid;
				role.halve    = mid;
			end else begin
				role.left_en  = IDX < n_eff;
				role.right_en = 1'b0;
				role.halve    = 1'b0;
			end
		end

		dmp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
			.clk      (clk),
			.load     (adv1),
			.sample   (samples[i]),
			.measure  (measure),
			.role     (role),
			.left_s1  (lane_l_s1[i]),
			.right_s1 (lane_r_s1[i])
		);
	end

	// adder tree over the lanes
	logic signed [SW-1:0] sum_l_s2;
	logic signed [SW-1:0] sum_r_s2;

	dmp_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
		.clk          (clk),
		.load         (adv2),
		.lane_left    (lane_l_s1),
		.lane_right   (lane_r_s1),
		.sum_left_s2  (sum_l_s2),
		.sum_right_s2 (sum_r_s2)
	);

	// running peaks, updated once as the word moves into stage three
	logic [dmp_pkg::PEAK_BITS-1:0] peak_left_q;
	logic [dmp_pkg::PEAK_BITS-1:0] peak_right_q;
	logic [dmp_pkg::PEAK_BITS-1:0] peak_l_nxt;
	logic [dmp_pkg::PEAK_BITS-1:0] peak_r_nxt;
	logic [dmp_pkg::PEAK_BITS-1:0] clamp_l;
	logic [dmp_pkg::PEAK_BITS-1:0] clamp_r;
	logic [dmp_pkg::PEAK_BITS-1:0] peak_s3;
	logic [dmp_pkg::PEAK_BITS-1:0] peak_s4;
	logic signed [CW-1:0]          wide_l;
	logic signed [CW-1:0]          wide_r;

	localparam logic signed [CW-1:0] PEAK_LIMIT = CW'(dmp_pkg::PEAK_MAX);

	always_comb begin
		wide_l  = CW'(sum_l_s2);
		wide_r  = CW'(sum_r_s2);
		clamp_l = (wide_l > PEAK_LIMIT) ? dmp_pkg::PEAK_MAX : dmp_pkg::PEAK_BITS'(wide_l);
		clamp_r = (wide_r > PEAK_LIMIT) ? dmp_pkg::PEAK_MAX : dmp_pkg::PEAK_BITS'(wide_r);

		peak_l_nxt = peak_left_q;
		peak_r_nxt = peak_right_q;
		unique case (op_s2)
			dmp_pkg::OP_MEASURE: begin
				if (clamp_l > peak_left_q) peak_l_nxt = clamp_l;
				if (stereo_out_q && (clamp_r > peak_right_q)) peak_r_nxt = clamp_r;
			end
			dmp_pkg::OP_CLEAR: begin
				peak_l_nxt = '0;
				peak_r_nxt = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_left_q  <= '0;
			peak_right_q <= '0;
		end else if (v_s2 && adv3) begin
			peak_left_q  <= peak_l_nxt;
			peak_right_q <= peak_r_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			peak_s3 <= (stereo_out_q && (peak_r_nxt > peak_l_nxt)) ? peak_r_nxt : peak_l_nxt;
		end
		if (adv4) begin
			peak_s4 <= peak_s3;
		end
	end

	// gain multiply and rounding; zero products unless mixing
	logic mix_l;
	logic mix_r;

	assign mix_l = (op_s2 == dmp_pkg::OP_MIX);
	assign mix_r = mix_l && stereo_out_q;

	dmp_gain #(.SAMPLE_BITS(SAMPLE_BITS)) u_gain (
		.clk       (clk),
		.load_s3   (adv3),
		.load_s4   (adv4),
		.mix_left  (mix_l),
		.mix_right (mix_r),
		.gain      (mix_gain_q),
		.sum_left  (sum_l_s2),
		.sum_right (sum_r_s2),
		.left_s4   (result.left_out),
		.right_s4  (result.right_out)
	);

	// output word
	assign result.valid    = v_s4;
	assign result.peak_sum = peak_s4;
endmodule

// ----- rtl/core/dmp_checker.sv -----
module dmp_checker #(
	parameter int SAMPLE_BITS = dmp_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [SAMPLE_BITS-1:0]        out_left,
	input logic [SAMPLE_BITS-1:0]        out_right,
	input logic [dmp_pkg::PEAK_BITS-1:0] out_peak
);
	// words inside the block, four stages at most
	logic [2:0] inflight_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_take && !out_take) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_take && !in_take) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left)
			&& $stable(out_right) && $stable(out_peak))
		else $error("result word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result word without a pending frame");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more frames in flight than pipeline stages");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("frame refused with empty output stage");
endmodule

bind multichannel_downmix_peak_top dmp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (frame.valid),
	.in_ready  (frame.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_left  (result.left_out),
	.out_right (result.right_out),
	.out_peak  (result.peak_sum)
);
